/* sv/psg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation sequence generator package
// Shared widths and constants for the generator, its RAM and its channels.
// ----------------------------------------------------------------------------
package psg_pkg;

    // Number of element slots held in the permutation store.
    localparam int MAX_ELEMS = 8;

    // Element value and store address widths.
    localparam int ELEM_W = $clog2(MAX_ELEMS);
    localparam int ADDR_W = $clog2(MAX_ELEMS);

    // Width of a size or scan count, which must be able to hold MAX_ELEMS itself.
    localparam int SIZE_W = $clog2(MAX_ELEMS + 1);

    // Packed result word: one nibble per shown element.
    localparam int WORD_W = 32;
    localparam int NIB_W  = 4;
    localparam int SHOWN  = WORD_W / NIB_W;

    // Configuration register.
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] MAX_SIZE_RESET = CFG_W'(8);

endpackage

/* sv/psg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation sequence generator channels
// Valid/ready interfaces for requests, results and the configuration write.
// ----------------------------------------------------------------------------

// Request channel: one transfer asks for the next permutation.
interface psg_req_if import psg_pkg::*; ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// Result channel: one transfer per request.
interface psg_res_if import psg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] perm_word;
    logic [SIZE_W-1:0] perm_size;
    logic              last_of_size;
    logic              last_overall;
    logic              exhausted;

    modport source (output valid, output perm_word, output perm_size,
                    output last_of_size, output last_overall, output exhausted,
                    input ready);
    modport sink   (input valid, input perm_word, input perm_size,
                    input last_of_size, input last_overall, input exhausted,
                    output ready);
endinterface

// Configuration channel: one transfer writes the maximum size register.
interface psg_cfg_if import psg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_size;

    modport source (output valid, output max_size, input ready);
    modport sink   (input valid, input max_size, output ready);
endinterface

/* sv/permutation_sequence_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation sequence generator
// Emits every permutation of 0..i-1 in lexicographic order for sizes 1 up to
// the configured maximum, one permutation per request transfer, then exhausted replies.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                      Transfer
//  -------  ---------  -------------------------------------------  -------------
//  req      in         restart                                      valid & ready
//  res      out        perm_word, perm_size, last_of_size,          valid & ready
//                      last_overall, exhausted
//  cfg      in         max_size                                     valid & ready
//
//  A request that advances the permutation runs the pivot search, successor search, swap,
//  suffix reversal and output scan; one that loads an identity writes it and then runs the
//  output scan, and an exhausted reply goes straight to ST_FIN. All element traffic goes
//  through one RAM with a single write port, scanned one element per cycle.
//  req.ready is high only while the sequencer is idle. A finished result waits in
//  the output register; the next request is taken meanwhile and stalls only in
//  its final state, ST_FIN, until res is free. Reset restores max_size to 8 and
//  marks the sequence as not started. cfg.ready is always high.
// ----------------------------------------------------------------------------
module permutation_sequence_generator import psg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    psg_req_if.sink   req,
    psg_res_if.source res,
    psg_cfg_if.sink   cfg
);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_IDENT  = 4'd1;
    localparam logic [3:0] ST_PIV    = 4'd2;
    localparam logic [3:0] ST_SUCC   = 4'd3;
    localparam logic [3:0] ST_SWAP1  = 4'd4;
    localparam logic [3:0] ST_SWAP2  = 4'd5;
    localparam logic [3:0] ST_REV_RD = 4'd6;
    localparam logic [3:0] ST_REV_W1 = 4'd7;
    localparam logic [3:0] ST_REV_W2 = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;
    localparam logic [3:0] ST_FIN    = 4'd10;

    // Control registers.
    logic [3:0]        state_reg, state_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic              vld_reg, vld_next;
    logic [SIZE_W-1:0] cur_size_reg, cur_size_next;
    logic              done_reg, done_next;
    logic              desc_reg, desc_next;
    logic              exh_reg, exh_next;
    logic              res_valid_reg, res_valid_next;
    logic [CFG_W-1:0]  max_size_reg;

    // Datapath registers.
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] p_reg, p_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ELEM_W-1:0] pval_reg, pval_next;
    logic [ELEM_W-1:0] jval_reg, jval_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [ELEM_W-1:0] tmp_reg, tmp_next;
    logic [ELEM_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] word_reg, word_next;

    // Output registers.
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic [SIZE_W-1:0] out_size_reg, out_size_next;
    logic              out_last_reg, out_last_next;
    logic              out_all_reg, out_all_next;
    logic              out_exh_reg, out_exh_next;

    // RAM ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ELEM_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [ELEM_W-1:0] ram_rd_a;
    logic [ELEM_W-1:0] ram_rd_b;

    // Helpers.
    logic [SIZE_W-1:0] limit;
    logic [SIZE_W-1:0] size_m1;
    logic [SIZE_W-1:0] cnt_inc;
    logic              last_all;

    // Element store.
    psg_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ELEMS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rd_a),
        .rdata_b (ram_rd_b)
    );

    // Effective maximum size, clamped to the store depth, with a setting of zero taken as 1.
    always_comb
    begin
        if (max_size_reg == '0)
        begin
            limit = SIZE_W'(1);
        end
        else if (SIZE_W'(max_size_reg) > SIZE_W'(MAX_ELEMS))
        begin
            limit = SIZE_W'(MAX_ELEMS);
        end
        else
        begin
            limit = SIZE_W'(max_size_reg);
        end
    end

    assign size_m1  = cur_size_reg - SIZE_W'(1);
    assign cnt_inc  = cnt_reg + SIZE_W'(1);
    assign last_all = desc_reg && (cur_size_reg >= limit);

    // Channel handshakes and output payload.
    assign req.ready        = (state_reg == ST_IDLE);
    assign cfg.ready        = 1'b1;
    assign res.valid        = res_valid_reg;
    assign res.perm_word    = out_word_reg;
    assign res.perm_size    = out_size_reg;
    assign res.last_of_size = out_last_reg;
    assign res.last_overall = out_all_reg;
    assign res.exhausted    = out_exh_reg;

    // Sequencer: scans read one position per cycle and use the read data in the next cycle.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        vld_next       = 1'b0;
        cur_size_next  = cur_size_reg;
        done_next      = done_reg;
        desc_next      = desc_reg;
        exh_next       = exh_reg;
        res_valid_next = res_valid_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        j_next         = j_reg;
        pval_next      = pval_reg;
        jval_next      = jval_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        tmp_next       = tmp_reg;
        prev_next      = prev_reg;
        word_next      = word_reg;
        out_word_next  = out_word_reg;
        out_size_next  = out_size_reg;
        out_last_next  = out_last_reg;
        out_all_next   = out_all_reg;
        out_exh_next   = out_exh_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr_a    = '0;
        ram_raddr_b    = '0;

        // A waiting result leaves on its transfer.
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    exh_next = 1'b0;
                    cnt_next = '0;
                    priority if (req.restart || (cur_size_reg == '0))
                    begin
                        cur_size_next = SIZE_W'(1);
                        done_next     = 1'b0;
                        state_next    = ST_IDENT;
                    end
                    else if (done_reg)
                    begin
                        exh_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (desc_reg)
                    begin
                        cur_size_next = cur_size_reg + SIZE_W'(1);
                        state_next    = ST_IDENT;
                    end
                    else
                    begin
                        state_next = ST_PIV;
                    end
                end
            end

            // Write the identity permutation, one element per cycle.
            ST_IDENT:
            begin
                if (cnt_reg < cur_size_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[ADDR_W-1:0];
                    ram_wdata = cnt_reg[ELEM_W-1:0];
                    cnt_next  = cnt_inc;
                end
                else
                begin
                    cnt_next   = '0;
                    word_next  = '0;
                    desc_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end

            // Pivot search: the rightmost position followed by a larger element.
            ST_PIV:
            begin
                if (vld_reg && (ram_rd_a < ram_rd_b))
                begin
                    p_next    = idx_reg;
                    pval_next = ram_rd_a;
                end
                if (cnt_reg < size_m1)
                begin
                    ram_raddr_a = cnt_reg[ADDR_W-1:0];
                    ram_raddr_b = cnt_inc[ADDR_W-1:0];
                    vld_next    = 1'b1;
                    idx_next    = cnt_reg[ADDR_W-1:0];
                    cnt_next    = cnt_inc;
                end
                else
                begin
                    cnt_next   = SIZE_W'(p_next) + SIZE_W'(1);
                    state_next = ST_SUCC;
                end
            end

            // Successor search: the rightmost element after the pivot that exceeds it.
            ST_SUCC:
            begin
                if (vld_reg && (ram_rd_a > pval_reg))
                begin
                    j_next    = idx_reg;
                    jval_next = ram_rd_a;
                end
                if (cnt_reg < cur_size_reg)
                begin
                    ram_raddr_a = cnt_reg[ADDR_W-1:0];
                    vld_next    = 1'b1;
                    idx_next    = cnt_reg[ADDR_W-1:0];
                    cnt_next    = cnt_inc;
                end
                else
                begin
                    state_next = ST_SWAP1;
                end
            end

            // Swap pivot and successor, one write in ST_SWAP1 and one in ST_SWAP2.
            ST_SWAP1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = p_reg;
                ram_wdata  = jval_reg;
                state_next = ST_SWAP2;
            end

            ST_SWAP2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg;
                ram_wdata  = pval_reg;
                lo_next    = p_reg + ADDR_W'(1);
                hi_next    = size_m1[ADDR_W-1:0];
                state_next = ST_REV_RD;
            end

            // Suffix reversal: read both ends, then write them back crossed.
            ST_REV_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr_a = lo_reg;
                    ram_raddr_b = hi_reg;
                    state_next  = ST_REV_W1;
                end
                else
                begin
                    cnt_next   = '0;
                    word_next  = '0;
                    desc_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end

            ST_REV_W1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rd_b;
                tmp_next   = ram_rd_a;
                state_next = ST_REV_W2;
            end

            ST_REV_W2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hi_reg;
                ram_wdata  = tmp_reg;
                lo_next    = lo_reg + ADDR_W'(1);
                hi_next    = hi_reg - ADDR_W'(1);
                state_next = ST_REV_RD;
            end

            // Output scan: pack the word and check whether the result descends.
            ST_OUT:
            begin
                if (vld_reg)
                begin
                    if (int'(idx_reg) < SHOWN)
                    begin
                        word_next[NIB_W*idx_reg +: NIB_W] = NIB_W'(ram_rd_a);
                    end
                    if ((idx_reg != '0) && (prev_reg < ram_rd_a))
                    begin
                        desc_next = 1'b0;
                    end
                    prev_next = ram_rd_a;
                end
                if (cnt_reg < cur_size_reg)
                begin
                    ram_raddr_a = cnt_reg[ADDR_W-1:0];
                    vld_next    = 1'b1;
                    idx_next    = cnt_reg[ADDR_W-1:0];
                    cnt_next    = cnt_inc;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            // Hand the result to the output register once it is free.
            ST_FIN:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    if (exh_reg)
                    begin
                        out_word_next = '0;
                        out_size_next = '0;
                        out_last_next = 1'b0;
                        out_all_next  = 1'b0;
                        out_exh_next  = 1'b1;
                    end
                    else
                    begin
                        out_word_next = word_reg;
                        out_size_next = cur_size_reg;
                        out_last_next = desc_reg;
                        out_all_next  = last_all;
                        out_exh_next  = 1'b0;
                        done_next     = last_all;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            vld_reg       <= 1'b0;
            cur_size_reg  <= '0;
            done_reg      <= 1'b0;
            desc_reg      <= 1'b1;
            exh_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            max_size_reg  <= MAX_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            vld_reg       <= vld_next;
            cur_size_reg  <= cur_size_next;
            done_reg      <= done_next;
            desc_reg      <= desc_next;
            exh_reg       <= exh_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                max_size_reg <= cfg.max_size;
            end
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        p_reg        <= p_next;
        j_reg        <= j_next;
        pval_reg     <= pval_next;
        jval_reg     <= jval_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        tmp_reg      <= tmp_next;
        prev_reg     <= prev_next;
        word_reg     <= word_next;
        out_word_reg <= out_word_next;
        out_size_reg <= out_size_next;
        out_last_reg <= out_last_next;
        out_all_reg  <= out_all_next;
        out_exh_reg  <= out_exh_next;
    end

    // The current size never grows past the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_size_reg <= SIZE_W'(MAX_ELEMS))
        else $error("current size exceeds store depth");

    // An exhausted reply carries no permutation.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && out_exh_reg |-> (out_size_reg == '0) && (out_word_reg == '0))
        else $error("exhausted result carries a permutation");

    // The last permutation overall is always the last of its size.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && out_all_reg |-> out_last_reg)
        else $error("last_overall without last_of_size");

    // An accepted request keeps the sequencer busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted back to back");

endmodule

/* sv/psg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module psg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
